/* rtl/ecd_pkg.sv */
// shared widths, register indexes and element size table for the escape command deframer
package ecd_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int LEFT_W   = 12;
    localparam int HDR_W    = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [HDR_W-1:0] HDR_BYTES  = 4'd12;
    localparam logic [BYTE_W-1:0] TYPE_COUNT = 8'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED = 1'b1;

    localparam logic [BYTE_W-1:0] ESCAPE_RESET   = 8'd27;
    localparam logic [BYTE_W-1:0] EXTENDED_RESET = 8'd255;

    // log2 of the element size for the known type codes
    function automatic logic [1:0] elem_shift(input logic [BYTE_W-1:0] type_code);
        logic [1:0] sh;
        case (type_code)
            8'd0, 8'd1: sh = 2'd0;
            8'd2, 8'd3: sh = 2'd1;
            8'd4, 8'd5: sh = 2'd2;
            8'd6, 8'd7: sh = 2'd3;
            8'd8:       sh = 2'd2;
            8'd9:       sh = 2'd3;
            default:    sh = 2'd0;
        endcase
        return sh;
    endfunction

endpackage

/* rtl/ecd_if.sv */
// stream interfaces for received bytes and deframed results
interface ecd_in_if import ecd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface ecd_out_if import ecd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [BYTE_W-1:0]        data_byte;
    logic signed [WORD_W-1:0] function_code;
    logic [WORD_W-1:0]        window_handle;
    logic [WORD_W-1:0]        channel_handle;
    logic [BYTE_W-1:0]        data_type;
    logic                     last;
    logic                     bad_type;

    modport source (output valid, output kind, output data_byte, output function_code,
                    output window_handle, output channel_handle, output data_type,
                    output last, output bad_type, input ready);
    modport sink   (input valid, input kind, input data_byte, input function_code,
                    input window_handle, input channel_handle, input data_type,
                    input last, input bad_type, output ready);
endinterface

/* rtl/escape_command_deframer_top.sv */
// escape command deframer: splits a serial byte stream into text bytes and command payload bytes
//
// Each received byte is taken into an input register, decoded against the frame phase and,
// if it yields a result, written to a result register. The block takes one request per cycle
// unless the input register is held; the input register holds a byte only while the result
// register is full and not being taken and that byte would produce a result. Frame bytes
// (escape, function, type, count and the twelve extended header bytes) produce no result.
// Each payload byte carries the latched function, window, channel and type fields and is
// marked last at the end of the frame. An operation of 1 returns the block to text mode and
// keeps the latched fields. Configuration writes are meant for an idle block.
module escape_command_deframer_top import ecd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    ecd_in_if.sink               i_in,
    ecd_out_if.source            o_out
);

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_FUNC,
        PH_SHORT,
        PH_LONG,
        PH_COUNT,
        PH_PAYLOAD
    } t_phase;

    // configuration
    logic [BYTE_W-1:0] r_escape;
    logic [BYTE_W-1:0] r_extended;

    // input register
    logic              r_in_valid;
    logic              r_in_op;
    logic [BYTE_W-1:0] r_in_byte;

    // frame state
    t_phase            r_phase,  n_phase;
    logic [WORD_W-1:0] r_func,   n_func;
    logic [WORD_W-1:0] r_window, n_window;
    logic [WORD_W-1:0] r_chan,   n_chan;
    logic [BYTE_W-1:0] r_type,   n_type;
    logic [LEFT_W-1:0] r_left,   n_left;
    logic [HDR_W-1:0]  r_hdr,    n_hdr;
    logic              r_bad,    n_bad;

    // result register
    logic                     r_out_valid;
    logic                     r_o_kind,    n_o_kind;
    logic [BYTE_W-1:0]        r_o_byte;
    logic [WORD_W-1:0]        r_o_func,    n_o_func;
    logic [WORD_W-1:0]        r_o_window,  n_o_window;
    logic [WORD_W-1:0]        r_o_chan,    n_o_chan;
    logic [BYTE_W-1:0]        r_o_type,    n_o_type;
    logic                     r_o_last,    n_o_last;
    logic                     r_o_bad,     n_o_bad;

    logic              w_produce;
    logic              w_advance;
    logic [LEFT_W-1:0] w_left_dec;
    logic [LEFT_W-1:0] w_count_p1;

    assign w_left_dec = r_left - LEFT_W'(1);
    assign w_count_p1 = LEFT_W'(r_in_byte) + LEFT_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_func     = r_func;
        n_window   = r_window;
        n_chan     = r_chan;
        n_type     = r_type;
        n_left     = r_left;
        n_hdr      = r_hdr;
        n_bad      = r_bad;
        w_produce  = 1'b0;
        n_o_kind   = 1'b0;
        n_o_func   = '0;
        n_o_window = '0;
        n_o_chan   = '0;
        n_o_type   = '0;
        n_o_last   = 1'b0;
        n_o_bad    = 1'b0;
        if (r_in_op) begin
            n_phase = PH_TEXT;
        end else begin
            unique case (r_phase)
                PH_FUNC: begin
                    n_func = WORD_W'(r_in_byte);
                    if (r_in_byte == r_extended) begin
                        n_hdr   = '0;
                        n_phase = PH_LONG;
                    end else begin
                        n_hdr   = HDR_BYTES;
                        n_phase = PH_SHORT;
                    end
                end
                PH_SHORT: begin
                    n_window = '0;
                    n_chan   = WORD_W'(r_in_byte[3:0]);
                    n_type   = BYTE_W'(r_in_byte[7:4]);
                    n_phase  = PH_COUNT;
                end
                PH_LONG: begin
                    n_type  = r_in_byte;
                    n_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    if (r_type < TYPE_COUNT) begin
                        n_bad  = 1'b0;
                        n_left = w_count_p1 << elem_shift(r_type);
                    end else begin
                        n_bad  = 1'b1;
                        n_left = w_count_p1;
                    end
                    n_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (r_hdr < HDR_BYTES) begin
                        // little-endian header: function, window, channel
                        case (r_hdr[3:2])
                            2'd0:    n_func[r_hdr[1:0]*8 +: 8]   = r_in_byte;
                            2'd1:    n_window[r_hdr[1:0]*8 +: 8] = r_in_byte;
                            default: n_chan[r_hdr[1:0]*8 +: 8]   = r_in_byte;
                        endcase
                        n_hdr = r_hdr + HDR_W'(1);
                    end else begin
                        n_left     = w_left_dec;
                        w_produce  = 1'b1;
                        n_o_kind   = 1'b1;
                        n_o_func   = r_func;
                        n_o_window = r_window;
                        n_o_chan   = r_chan;
                        n_o_type   = r_type;
                        n_o_last   = (w_left_dec == '0);
                        n_o_bad    = r_bad;
                        if (w_left_dec == '0) begin
                            n_phase = PH_TEXT;
                        end
                    end
                end
                default: begin
                    if (r_in_byte == r_escape) begin
                        n_phase = PH_FUNC;
                    end else begin
                        n_phase   = PH_TEXT;
                        w_produce = 1'b1;
                    end
                end
            endcase
        end
    end

    // a byte with no result never waits on the result register
    assign w_advance  = r_in_valid && (!w_produce || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape    <= ESCAPE_RESET;
            r_extended  <= EXTENDED_RESET;
            r_in_valid  <= 1'b0;
            r_phase     <= PH_TEXT;
            r_func      <= '0;
            r_window    <= '0;
            r_chan      <= '0;
            r_type      <= '0;
            r_left      <= '0;
            r_hdr       <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ESCAPE:   r_escape   <= i_cfg_data;
                    CFG_EXTENDED: r_extended <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_phase  <= n_phase;
                r_func   <= n_func;
                r_window <= n_window;
                r_chan   <= n_chan;
                r_type   <= n_type;
                r_left   <= n_left;
                r_hdr    <= n_hdr;
                r_bad    <= n_bad;
            end
            if (w_advance && w_produce) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_op   <= i_in.operation;
            r_in_byte <= i_in.rx_byte;
        end
        if (w_advance && w_produce) begin
            r_o_kind   <= n_o_kind;
            r_o_byte   <= r_in_byte;
            r_o_func   <= n_o_func;
            r_o_window <= n_o_window;
            r_o_chan   <= n_o_chan;
            r_o_type   <= n_o_type;
            r_o_last   <= n_o_last;
            r_o_bad    <= n_o_bad;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_o_kind;
    assign o_out.data_byte      = r_o_byte;
    assign o_out.function_code  = $signed(r_o_func);
    assign o_out.window_handle  = r_o_window;
    assign o_out.channel_handle = r_o_chan;
    assign o_out.data_type      = r_o_type;
    assign o_out.last           = r_o_last;
    assign o_out.bad_type       = r_o_bad;

    a_plain_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.kind |-> o_out.function_code == 0 && o_out.window_handle == 0
            && o_out.channel_handle == 0 && o_out.data_type == 0 && !o_out.last
            && !o_out.bad_type)
        else $error("plain byte carries frame fields");

    a_break_to_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in_op |=> r_phase == PH_TEXT)
        else $error("line break did not return to text mode");

    a_header_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_hdr <= HDR_BYTES)
        else $error("header index past header length");

    a_header_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && !r_in_op && r_phase == PH_PAYLOAD && r_hdr < HDR_BYTES |-> !w_produce)
        else $error("header byte produced a result");

endmodule
